// File: rtl/sst_pkg.sv
// Shared types and constants for the sorted set table.
// No dependencies; used by sorted_set_table_top.
package sst_pkg;

  localparam int unsigned DefCapacity = 64;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned CountW      = 7;

  // Operation codes carried on in_mode.
  localparam logic [1:0] OpInsert = 2'd0;
  localparam logic [1:0] OpDelete = 2'd1;
  localparam logic [1:0] OpSearch = 2'd2;
  localparam logic [1:0] OpClear  = 2'd3;

  // Result status codes.
  localparam logic [1:0] StDone  = 2'd0;
  localparam logic [1:0] StDup   = 2'd1;
  localparam logic [1:0] StAbsent = 2'd2;
  localparam logic [1:0] StFull  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_SHUP,
    S_SHDN,
    S_DONE
  } state_t;

endpackage

// File: rtl/sst_ram.sv
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
module sst_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/sorted_set_table_top.sv
// Top level of the sorted set table: control sequencer around one key RAM.
// Depends on sst_pkg and sst_ram.
//
// Usage: raise start with in_mode and in_key while busy is low; the transaction
// is taken at that edge and busy rises on the next cycle. The result appears
// on out_found, out_status and out_count for one cycle, marked by out_valid.
// The receiver cannot stall; results are never held.
// A clear goes from the accept cycle straight to the strobe cycle.
// Other operations run a binary search in which each probe first issues the
// RAM read and then compares, with at most clog2(count+1) probes; an empty
// set still passes through the search state. An insert or delete then moves
// each entry above the key position one at a time through the single RAM
// write port, a read and then a write per moved entry, and the result strobe
// follows. A new transaction is taken the cycle after the strobe.
// Reset (rst_n low, synchronous) empties the set; the RAM contents are not
// cleared, as only entries below the count are ever read.
module sorted_set_table_top #(
  parameter int unsigned Capacity = sst_pkg::DefCapacity
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_mode,
  input  logic signed [63:0]        in_key,
  output logic                      out_valid,
  output logic                      out_found,
  output logic [1:0]                out_status,
  output logic [sst_pkg::CountW-1:0] out_count
);

  localparam int unsigned AW = $clog2(Capacity);
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam logic [CW-1:0] CapC = CW'(Capacity);

  sst_pkg::state_t state_r, state_nxt;
  logic [1:0]     mode_r, mode_nxt;
  logic [63:0]    key_r, key_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0]  ptr_r, ptr_nxt;
  logic           rdpend_r, rdpend_nxt;
  logic           found_r, found_nxt;
  logic [1:0]     status_r, status_nxt;
  logic           shup_r;

  logic           we;
  logic [AW-1:0]  waddr, raddr;
  logic [63:0]    wdata, rdata;
  logic [CW-1:0]  mid;
  logic           less;
  logic           eq;
  logic           fin_we;
  logic           we_q;
  logic [AW-1:0]  wa_q;
  logic [63:0]    wd_q;

  sst_ram #(.Width(sst_pkg::KeyW), .Depth(Capacity)) u_ram (
    .clk, .we(we_q), .waddr(wa_q), .wdata(wd_q), .raddr, .rdata
  );

  // Keys are stored sign-flipped so unsigned compare gives signed order.
  assign mid  = lo_r + ((hi_r - lo_r) >> 1);
  assign less = rdata < key_r;
  assign eq   = rdata == key_r;

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sst_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = (in_mode == sst_pkg::OpClear) ? sst_pkg::S_DONE : sst_pkg::S_SRCH;
        end
      end
      sst_pkg::S_SRCH: begin
        if (rdpend_r && !(lo_nxt < hi_nxt) || !rdpend_r && !(lo_r < hi_r)) begin
          state_nxt = sst_pkg::S_DONE;
          if (mode_r == sst_pkg::OpInsert && !found_nxt && cnt_r < CapC && lo_nxt < cnt_r) begin
            state_nxt = sst_pkg::S_SHUP;
          end else if (mode_r == sst_pkg::OpDelete && found_nxt && lo_nxt + 1'b1 < cnt_r) begin
            state_nxt = sst_pkg::S_SHDN;
          end
        end
      end
      sst_pkg::S_SHUP: begin
        if (rdpend_r && ptr_r == lo_r) begin
          state_nxt = sst_pkg::S_DONE;
        end
      end
      sst_pkg::S_SHDN: begin
        if (rdpend_r && ptr_r + CW'(2) == cnt_r) begin
          state_nxt = sst_pkg::S_DONE;
        end
      end
      sst_pkg::S_DONE: state_nxt = sst_pkg::S_IDLE;
      default: state_nxt = sst_pkg::S_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    mode_nxt   = mode_r;
    key_nxt    = key_r;
    cnt_nxt    = cnt_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    ptr_nxt    = ptr_r;
    rdpend_nxt = 1'b0;
    found_nxt  = found_r;
    status_nxt = status_r;
    we         = 1'b0;
    waddr      = ptr_r[AW-1:0];
    wdata      = rdata;
    raddr      = mid[AW-1:0];
    case (state_r)
      sst_pkg::S_IDLE: begin
        if (start) begin
          mode_nxt   = in_mode;
          key_nxt    = {~in_key[63], in_key[62:0]};
          lo_nxt     = '0;
          hi_nxt     = cnt_r;
          found_nxt  = 1'b0;
          status_nxt = sst_pkg::StDone;
          if (in_mode == sst_pkg::OpClear) begin
            cnt_nxt = '0;
          end
        end
      end
      sst_pkg::S_SRCH: begin
        // Each probe issues the read, then compares.
        if (rdpend_r) begin
          if (less) begin
            lo_nxt = mid + 1'b1;
          end else begin
            hi_nxt = mid;
          end
          if (eq) begin
            found_nxt = 1'b1;
          end
        end else if (lo_r < hi_r) begin
          rdpend_nxt = 1'b1;
        end
        if (rdpend_r && !(lo_nxt < hi_nxt) || !rdpend_r && !(lo_r < hi_r)) begin
          // Position settled; decide the update.
          case (mode_r)
            sst_pkg::OpInsert: begin
              if (found_nxt) begin
                status_nxt = sst_pkg::StDup;
              end else if (cnt_r >= CapC) begin
                status_nxt = sst_pkg::StFull;
              end else if (lo_nxt < cnt_r) begin
                ptr_nxt = cnt_r - 1'b1;
              end else begin
                we      = 1'b1;
                waddr   = lo_nxt[AW-1:0];
                wdata   = key_r;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            sst_pkg::OpDelete: begin
              if (!found_nxt) begin
                status_nxt = sst_pkg::StAbsent;
              end else if (lo_nxt + 1'b1 < cnt_r) begin
                ptr_nxt = lo_nxt;
              end else begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      sst_pkg::S_SHUP: begin
        // Move entry ptr to ptr+1, downward from the top; then write the key.
        raddr = ptr_r[AW-1:0];
        if (rdpend_r) begin
          we    = 1'b1;
          waddr = AW'(ptr_r + 1'b1);
          if (ptr_r == lo_r) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ptr_nxt = ptr_r - 1'b1;
          end
        end else begin
          rdpend_nxt = 1'b1;
        end
        if (rdpend_r && ptr_r == lo_r) begin
          rdpend_nxt = 1'b0;
        end
      end
      sst_pkg::S_SHDN: begin
        // Move entry ptr+1 to ptr, upward from the key position, up to the last entry.
        raddr = AW'(ptr_r + 1'b1);
        if (rdpend_r) begin
          we      = 1'b1;
          waddr   = ptr_r[AW-1:0];
          ptr_nxt = ptr_r + 1'b1;
          if (ptr_r + CW'(2) == cnt_r) begin
            cnt_nxt = cnt_r - 1'b1;
          end
        end else begin
          rdpend_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // The final key write of an insert lands in the DONE cycle.
  assign fin_we = state_r == sst_pkg::S_DONE && mode_r == sst_pkg::OpInsert
                  && status_r == sst_pkg::StDone && ptr_r == lo_r && shup_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sst_pkg::S_IDLE;
      cnt_r    <= '0;
      rdpend_r <= 1'b0;
      shup_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      rdpend_r <= rdpend_nxt;
      shup_r   <= state_r == sst_pkg::S_SHUP;
    end
    mode_r   <= mode_nxt;
    key_r    <= key_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    ptr_r    <= ptr_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

  // Second RAM write path is avoided: the key write reuses the port in DONE.
  always_comb begin
    we_q = we | fin_we;
    wa_q = fin_we ? lo_r[AW-1:0] : waddr;
    wd_q = fin_we ? key_r : wdata;
  end

  assign busy       = state_r != sst_pkg::S_IDLE;
  assign out_valid  = state_r == sst_pkg::S_DONE;
  assign out_found  = found_r & (mode_r != sst_pkg::OpClear);
  assign out_status = status_r;
  assign out_count  = sst_pkg::CountW'(cnt_r);

`ifndef SYNTHESIS
  // The count never exceeds the capacity.
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CapC)
    else $error("count above capacity");
  // A result follows an accepted clear in the next cycle.
  a_clr_lat: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_mode == sst_pkg::OpClear |=> out_valid && out_count == '0)
    else $error("clear result missing");
  // An insert is refused only when the set is at capacity.
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sst_pkg::StFull |-> cnt_r == CapC)
    else $error("full refusal with room left");
`endif

endmodule
